>>> hw/rtl/ptbl_pkg.sv
// shared constants for the per-user token bucket limiter
package ptbl_pkg;
	localparam int unsigned TableDepth = 4096;
	localparam logic [31:0] HashMult = 32'd2654435761;
	localparam logic [7:0] CapReset = 8'd10;
	localparam logic [15:0] PeriodReset = 16'd1;
	localparam logic [1:0] ST_SPENT = 2'd0;
	localparam logic [1:0] ST_THROTTLED = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_BYPASS = 2'd3;
	localparam logic [0:0] REG_CAPACITY = 1'd0;
	localparam logic [0:0] REG_PERIOD = 1'd1;
endpackage

>>> hw/rtl/per_user_token_bucket_limiter_core.sv
// per-user token bucket limiter: table, probe sequencer and refill divider
// timing: a bypassed id has its result in the cycle after the start transfer; otherwise
// each probe reads then checks a slot, a refill adds a division, and a write step ends it.
// flow: one item at a time, the next start is taken at the result transfer edge;
// bypassed ids go back to back; a full table reports after every slot has been probed.
// reset: capacity 10, period 1; a clearing pass over every slot empties the table
// before the first start is taken (busy high meanwhile); the receiver cannot stall.
module per_user_token_bucket_limiter_core #(
	parameter int unsigned TABLE_DEPTH = ptbl_pkg::TableDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic signed [31:0] user_id,
	input  logic [31:0] now_seconds,
	output logic        done,
	output logic        allowed,
	output logic [1:0]  status,
	output logic [7:0]  tokens_left,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [AW:0] DEPTH_C = (AW+1)'(TABLE_DEPTH);

	localparam logic [2:0] S_CLEAR = 3'd0, S_IDLE = 3'd1, S_READ = 3'd2,
		S_CHECK = 3'd3, S_DIV = 3'd4, S_WRITE = 3'd5;

	logic [2:0]  state_q;
	logic [7:0]  cap_q;
	logic [15:0] period_q;
	logic [30:0] id_q;
	logic [31:0] now_q;
	logic [AW-1:0] addr_q;
	logic [AW:0] probes_q;
	logic [7:0]  tok_q;
	// whether last time should move: kept in a flag
	logic        refill_q;
	logic [31:0] last_q;

	logic [30:0] mem_user [TABLE_DEPTH];
	logic [7:0]  mem_tok  [TABLE_DEPTH];
	logic [31:0] mem_time [TABLE_DEPTH];
	logic [30:0] rd_user;
	logic [7:0]  rd_tok;
	logic [31:0] rd_time;
	logic        we;
	logic [30:0] wr_user;
	logic [7:0]  wr_tok;
	logic [31:0] wr_time;
	logic [31:0] time_wr;

	logic [31:0] hash;
	logic        div_go, div_done;
	logic [8:0]  div_q;
	logic [15:0] period_eff;
	logic [32:0] elapsed;
	logic [9:0]  sum;
	logic [7:0]  refilled;

	assign hash = 32'(user_id) * ptbl_pkg::HashMult;
	assign period_eff = (period_q == 16'd0) ? 16'd1 : period_q;
	assign busy = (state_q != S_IDLE);
	assign cfg_ready = !busy;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_user[addr_q] <= wr_user;
			mem_tok[addr_q]  <= wr_tok;
			mem_time[addr_q] <= wr_time;
		end
		rd_user <= mem_user[addr_q];
		rd_tok  <= mem_tok[addr_q];
		rd_time <= mem_time[addr_q];
	end

	ptbl_div u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go), .dividend(elapsed[31:0]),
		.divisor(period_eff), .done(div_done), .quotient(div_q)
	);

	// signed elapsed time, one bit wider than the time stamps
	assign elapsed = {1'b0, now_q} - {1'b0, ((rd_user == 31'd0) ? now_q : rd_time)};
	assign sum = {2'b00, tok_q} + {1'b0, div_q};
	assign refilled = (sum > {2'b00, cap_q}) ? cap_q : sum[7:0];
	assign time_wr = refill_q ? now_q : last_q;

	always_comb begin
		we = 1'b0;
		wr_user = id_q;
		wr_tok = tok_q;
		wr_time = time_wr;
		div_go = 1'b0;
		if (state_q == S_CLEAR) begin
			we = 1'b1;
			wr_user = '0;
		end else if (state_q == S_WRITE) begin
			we = 1'b1;
			wr_tok = (tok_q != 8'd0) ? tok_q - 8'd1 : 8'd0;
		end
		if (state_q == S_CHECK && !((rd_user != 31'd0 && rd_user != id_q)) &&
				!elapsed[32] && elapsed[31:0] >= {16'd0, period_eff})
			div_go = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CHECK) last_q <= (rd_user == 31'd0) ? now_q : rd_time;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			addr_q      <= '0;
			probes_q    <= '0;
			cap_q       <= ptbl_pkg::CapReset;
			period_q    <= ptbl_pkg::PeriodReset;
			done        <= 1'b0;
			refill_q    <= 1'b0;
			allowed     <= 1'b0;
			status      <= ptbl_pkg::ST_SPENT;
			tokens_left <= '0;
			id_q        <= '0;
			now_q       <= '0;
			tok_q       <= '0;
		end else begin
			done <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == ptbl_pkg::REG_CAPACITY) cap_q <= cfg_data[7:0];
				else period_q <= cfg_data;
			end
			case (state_q)
				S_CLEAR: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == AW'(TABLE_DEPTH - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						if (user_id <= 0) begin
							done <= 1'b1;
							allowed <= 1'b1;
							status <= ptbl_pkg::ST_BYPASS;
							tokens_left <= 8'd0;
						end else begin
							id_q <= user_id[30:0];
							now_q <= now_seconds;
							addr_q <= hash[AW-1:0];
							probes_q <= '0;
							state_q <= S_READ;
						end
					end
				end
				S_READ: state_q <= S_CHECK;
				S_CHECK: begin
					if (rd_user != 31'd0 && rd_user != id_q) begin
						if (probes_q + 1'b1 == DEPTH_C) begin
							done <= 1'b1;
							allowed <= 1'b1;
							status <= ptbl_pkg::ST_FULL;
							tokens_left <= 8'd0;
							state_q <= S_IDLE;
						end else begin
							probes_q <= probes_q + 1'b1;
							addr_q <= addr_q + 1'b1;
							state_q <= S_READ;
						end
					end else begin
						tok_q <= (rd_user == 31'd0) ? cap_q : rd_tok;
						refill_q <= div_go;
						state_q <= div_go ? S_DIV : S_WRITE;
					end
				end
				S_DIV: begin
					if (div_done) begin
						tok_q <= refilled;
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					done <= 1'b1;
					allowed <= (tok_q != 8'd0);
					status <= (tok_q != 8'd0) ? ptbl_pkg::ST_SPENT : ptbl_pkg::ST_THROTTLED;
					tokens_left <= (tok_q != 8'd0) ? tok_q - 8'd1 : 8'd0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result strobe while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> busy) else $error("not busy while dividing");
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && !allowed) |-> (status == ptbl_pkg::ST_THROTTLED))
		else $error("throttle without throttled status");
endmodule

>>> hw/rtl/ptbl_div.sv
// restoring divider, one quotient bit per cycle, quotient saturated to 9 bits
module ptbl_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [31:0] dividend,
	input  logic [15:0] divisor,
	output logic        done,
	output logic [8:0]  quotient
);
	logic [31:0] quo_q;
	logic [16:0] rem_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic [16:0] trial;
	logic [16:0] diff;

	assign trial = {rem_q[15:0], quo_q[31]};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= 6'd0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			if (!diff[16]) begin
				rem_q <= diff;
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign quotient = (|quo_q[31:9]) ? 9'h1FF : quo_q[8:0];
endmodule
